// File: design/capkb_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the capacitive key baseline detector.
// No dependencies; the interfaces and the top module import it.
package capkb_pkg;

  localparam int COLUMNS_DEF   = 18;
  localparam int ROWS          = 8;
  localparam int MIX_SHIFT_DEF = 3;
  localparam int AGG_SHIFT_DEF = 8;

  localparam int COL_W      = 5;
  localparam int SENSE_W    = 10;
  localparam int SMP_W      = 8;
  localparam int ACC_W      = 16;
  localparam int THR_W      = 8;
  localparam int WARM_W     = 11;
  localparam int SCAN_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam int PRESS_DELTA_MV = 380;
  localparam int MV_PER_STEP    = 5;

  localparam logic [SMP_W-1:0]  BASE_RESET      = 8'hB0;
  localparam logic [THR_W-1:0]  THRESHOLD_RESET = THR_W'((PRESS_DELTA_MV >> 1) / MV_PER_STEP);
  localparam logic [WARM_W-1:0] WARMUP_RESET    = 11'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_WARMUP    = 2'd1
  } cfg_idx_t;

endpackage

// File: design/capkb_ifs.sv
`timescale 1ns / 1ps
// Handshake channels of the detector: column scan items, results, config writes.
// Depends on capkb_pkg for field widths.
interface capkb_scan_if;
  import capkb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [COL_W-1:0]     column_index;
  logic [SENSE_W-1:0]   sense_0;
  logic [SENSE_W-1:0]   sense_1;
  logic [SENSE_W-1:0]   sense_2;
  logic [SENSE_W-1:0]   sense_3;
  logic [SENSE_W-1:0]   sense_4;
  logic [SENSE_W-1:0]   sense_5;
  logic [SENSE_W-1:0]   sense_6;
  logic [SENSE_W-1:0]   sense_7;
  logic                 scan_end;

  modport source (output valid, column_index, sense_0, sense_1, sense_2, sense_3,
                  sense_4, sense_5, sense_6, sense_7, scan_end, input ready);
  modport sink   (input valid, column_index, sense_0, sense_1, sense_2, sense_3,
                  sense_4, sense_5, sense_6, sense_7, scan_end, output ready);
endinterface

interface capkb_result_if;
  import capkb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [COL_W-1:0]     column_out;
  logic [ROWS-1:0]      pressed_rows;
  logic                 map_changed;
  logic                 warmed_up;
  logic                 baselines_refreshed;

  modport source (output valid, column_out, pressed_rows, map_changed, warmed_up,
                  baselines_refreshed, input ready);
  modport sink   (input valid, column_out, pressed_rows, map_changed, warmed_up,
                  baselines_refreshed, output ready);
endinterface

interface capkb_cfg_if;
  import capkb_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/capkb_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module capkb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 18
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/capsense_key_baseline_detector_top.sv
`timescale 1ns / 1ps
// Capacitive key matrix detector with per-key baseline tracking.
// Uses capkb_pkg, the capkb_*_if channels and two capkb_ram instances.
//
// Usage:
//   scan   - one item per strobed column: column index, eight raw readings and
//            a flag on the last column of a full keyboard scan.
//   result - one item per column: pressed row map, change flag, warm-up state
//            and whether this scan end refreshed the baselines.
//   cfg    - register writes (index 0 press threshold, 1 warm-up scans),
//            always ready; write only while the block is idle.
// Result path: an accepted column waits in the read stage (ST_RD) until the
//   result register is free, then loads that register.
// Flow: a column is accepted in ST_IDLE; in ST_RD its baseline/accumulator
//   read is used and the accumulator is written back, and no new column is
//   taken until ST_IDLE again. A scan end that refreshes baselines adds a walk
//   over all columns (read, then write, per column) before the next column.
// Reset: per-column valid bits make baselines and accumulators read as 0xB0,
//   so there is no clearing pass; the block takes items right after reset.
// Stall: one output register holds the result; a column waiting in the read
//   stage holds until that register drains.
module capsense_key_baseline_detector_top #(
  parameter int COLUMNS   = capkb_pkg::COLUMNS_DEF,
  parameter int MIX_SHIFT = capkb_pkg::MIX_SHIFT_DEF,
  parameter int AGG_SHIFT = capkb_pkg::AGG_SHIFT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  capkb_scan_if.sink       scan,
  capkb_result_if.source   result,
  capkb_cfg_if.sink        cfg
);
  import capkb_pkg::*;

  localparam int COL_AW  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int BASE_WW = ROWS * SMP_W;
  localparam int ACC_WW  = ROWS * ACC_W;
  localparam int SUM_W   = ((SMP_W + MIX_SHIFT > ACC_W - AGG_SHIFT) ?
                            (SMP_W + MIX_SHIFT) : (ACC_W - AGG_SHIFT)) + 1;
  localparam logic [COL_AW-1:0] LAST_COL = COL_AW'(COLUMNS - 1);
  localparam logic [SUM_W-1:0]  SMP_MAX  = SUM_W'((1 << SMP_W) - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD   = 4'b0010,
    ST_WRD  = 4'b0100,
    ST_WWR  = 4'b1000
  } state_t;

  state_t              state;
  logic [THR_W-1:0]    thr;
  logic [WARM_W-1:0]   warm_scans;
  logic [COL_W-1:0]    item_col;
  logic [SMP_W-1:0]    item_smp [ROWS];
  logic                item_end;
  logic [COL_AW-1:0]   rd_addr;
  logic [COLUMNS-1:0]  base_live;
  logic [COLUMNS-1:0]  acc_live;
  logic [COLUMNS-1:0]  acc_zero;
  logic [ROWS-1:0]     col_map [COLUMNS];
  logic                pend;
  logic                act;
  logic [SCAN_W-1:0]   scan_cnt;
  logic [WARM_W-1:0]   warm_cnt;

  logic                out_valid;
  logic [COL_W-1:0]    out_col;
  logic [ROWS-1:0]     out_press;
  logic                out_chg;
  logic                out_warm;
  logic                out_ref;

  logic [SENSE_W-1:0]  sense_arr [ROWS];
  logic [BASE_WW-1:0]  base_rd;
  logic [BASE_WW-1:0]  base_wdata;
  logic [ACC_WW-1:0]   acc_rd;
  logic [ACC_WW-1:0]   acc_wdata;
  logic                base_we;
  logic                acc_we;
  logic                mem_re;
  logic [COL_AW-1:0]   mem_raddr;
  logic                scan_acc;
  logic                col_ok_in;
  logic                col_ok;
  logic                rd_go;
  logic                warm;
  logic [ROWS-1:0]     press;
  logic [ROWS-1:0]     map_cur;
  logic                chg;
  logic                pend_new;
  logic                act_new;
  logic [SCAN_W-1:0]   scan_next;
  logic [WARM_W-1:0]   warm_next;
  logic                pend_next;
  logic                act_next;
  logic                clear_all;
  logic                refresh;

  assign sense_arr[0] = scan.sense_0;
  assign sense_arr[1] = scan.sense_1;
  assign sense_arr[2] = scan.sense_2;
  assign sense_arr[3] = scan.sense_3;
  assign sense_arr[4] = scan.sense_4;
  assign sense_arr[5] = scan.sense_5;
  assign sense_arr[6] = scan.sense_6;
  assign sense_arr[7] = scan.sense_7;

  assign scan.ready = (state == ST_IDLE);
  assign cfg.ready  = 1'b1;
  assign scan_acc   = scan.valid && scan.ready;
  assign col_ok_in  = (scan.column_index < COL_W'(COLUMNS));
  assign col_ok     = (item_col < COL_W'(COLUMNS));
  assign rd_go      = (state == ST_RD) && (!out_valid || result.ready);

  assign mem_re    = (scan_acc && col_ok_in) || (state == ST_WRD);
  assign mem_raddr = (state == ST_IDLE) ? scan.column_index[COL_AW-1:0] : rd_addr;
  assign base_we   = (state == ST_WWR);
  assign acc_we    = rd_go && col_ok;

  // Per-row lanes: valid-bit substitution, press compare, accumulate, mix.
  for (genvar r = 0; r < ROWS; r++) begin : g_lane
    logic [SMP_W-1:0] base_k;
    logic [ACC_W-1:0] acc_k;
    logic [SUM_W-1:0] mix_sum;
    logic [SUM_W-1:0] mix_val;

    always_comb begin
      base_k = base_live[rd_addr] ? base_rd[r*SMP_W +: SMP_W] : BASE_RESET;
      if (acc_live[rd_addr]) begin
        acc_k = acc_rd[r*ACC_W +: ACC_W];
      end else if (acc_zero[rd_addr]) begin
        acc_k = '0;
      end else begin
        acc_k = ACC_W'(BASE_RESET);
      end
      press[r] = col_ok &&
                 ({1'b0, item_smp[r]} > ({1'b0, thr} + {1'b0, base_k}));
      acc_wdata[r*ACC_W +: ACC_W] = acc_k + ACC_W'(item_smp[r]);
      mix_sum = (SUM_W'(base_k) << MIX_SHIFT) - SUM_W'(base_k)
              + SUM_W'(acc_k >> AGG_SHIFT);
      mix_val = mix_sum >> MIX_SHIFT;
      base_wdata[r*SMP_W +: SMP_W] = (mix_val > SMP_MAX) ? SMP_MAX[SMP_W-1:0]
                                                         : mix_val[SMP_W-1:0];
    end
  end

  // Column update and scan-end bookkeeping, in the order of the item rules.
  always_comb begin
    warm      = (warm_cnt >= warm_scans);
    map_cur   = col_ok ? col_map[rd_addr] : '0;
    chg       = col_ok && warm && (press != map_cur);
    pend_new  = pend | chg;
    act_new   = act | (|press) | pend_new;
    scan_next = scan_cnt;
    warm_next = warm_cnt;
    pend_next = pend_new;
    act_next  = act_new;
    clear_all = 1'b0;
    refresh   = 1'b0;
    if (item_end) begin
      scan_next = scan_cnt + SCAN_W'(1);
      if (!warm) begin
        warm_next = warm_cnt + WARM_W'(1);
      end else begin
        if (pend_new) begin
          clear_all = 1'b1;
          scan_next = '0;
          act_next  = 1'b0;
          pend_next = 1'b0;
        end
        refresh = (scan_next == '0) && act_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr        <= THRESHOLD_RESET;
      warm_scans <= WARMUP_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_THRESHOLD: thr        <= cfg.data[THR_W-1:0];
        CFG_WARMUP:    warm_scans <= cfg.data[WARM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (scan_acc) begin
      item_col <= scan.column_index;
      item_end <= scan.scan_end;
      for (int r = 0; r < ROWS; r++) begin
        item_smp[r] <= sense_arr[r][SMP_W:1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_addr   <= '0;
      base_live <= '0;
      acc_live  <= '0;
      acc_zero  <= '0;
      pend      <= 1'b0;
      act       <= 1'b1;
      scan_cnt  <= '0;
      warm_cnt  <= '0;
      for (int c = 0; c < COLUMNS; c++) begin
        col_map[c] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (scan_acc) begin
            rd_addr <= scan.column_index[COL_AW-1:0];
            state   <= ST_RD;
          end
        end
        ST_RD: begin
          if (rd_go) begin
            scan_cnt <= scan_next;
            warm_cnt <= warm_next;
            pend     <= pend_next;
            act      <= act_next;
            if (chg) begin
              col_map[rd_addr] <= press;
            end
            // a pending change wipes every accumulator, this column's too
            if (clear_all) begin
              acc_live <= '0;
              acc_zero <= '1;
            end else if (acc_we) begin
              acc_live[rd_addr] <= 1'b1;
              acc_zero[rd_addr] <= 1'b0;
            end
            if (refresh) begin
              rd_addr <= '0;
              state   <= ST_WRD;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_WRD: begin
          state <= ST_WWR;
        end
        ST_WWR: begin
          base_live[rd_addr] <= 1'b1;
          acc_live[rd_addr]  <= 1'b0;
          acc_zero[rd_addr]  <= 1'b1;
          if (rd_addr == LAST_COL) begin
            state <= ST_IDLE;
          end else begin
            rd_addr <= rd_addr + COL_AW'(1);
            state   <= ST_WRD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_go) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_go) begin
      out_col   <= item_col;
      out_press <= press;
      out_chg   <= chg;
      out_warm  <= warm;
      out_ref   <= refresh;
    end
  end

  assign result.valid               = out_valid;
  assign result.column_out          = out_col;
  assign result.pressed_rows        = out_press;
  assign result.map_changed         = out_chg;
  assign result.warmed_up           = out_warm;
  assign result.baselines_refreshed = out_ref;

  capkb_ram #(
    .WIDTH (BASE_WW),
    .DEPTH (COLUMNS)
  ) u_base_ram (
    .clk   (clk),
    .we    (base_we),
    .waddr (rd_addr),
    .wdata (base_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (base_rd)
  );

  capkb_ram #(
    .WIDTH (ACC_WW),
    .DEPTH (COLUMNS)
  ) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (rd_addr),
    .wdata (acc_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (acc_rd)
  );

`ifndef SYNTHESIS
  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    scan.valid && scan.ready |=> state == ST_RD)
    else $error("accepted column did not enter the read stage");

  a_result_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state == ST_RD))
    else $error("result appeared without a column in the read stage");

  a_walk_clears_acc: assert property (@(posedge clk) disable iff (rst)
    state == ST_WWR && rd_addr == LAST_COL |=>
      acc_live == '0 && acc_zero == '1 && base_live == '1 && state == ST_IDLE)
    else $error("baseline walk ended with accumulators not cleared");

  a_clear_blocks_refresh: assert property (@(posedge clk) disable iff (rst)
    rd_go && clear_all |-> !refresh)
    else $error("refresh started on a scan end that cleared accumulators");
`endif

endmodule
